@@ sv/ihm_pkg.sv @@
`default_nettype none
package ihm_pkg;

    typedef enum logic [2:0] {
        OP_PUT  = 3'd0,
        OP_DEL  = 3'd1,
        OP_GET  = 3'd2,
        OP_PREV = 3'd3,
        OP_NEXT = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_WAIT,
        S_DECIDE,
        S_LINK_RD,
        S_LINK_WAIT,
        S_WRITE_A,
        S_WRITE_B,
        S_DEL_FIX,
        S_NBR_RD,
        S_NBR_WAIT,
        S_OUT
    } t_state;

    localparam logic [15:0] H0_INIT = 16'h8765;
    localparam logic [15:0] H1_INIT = 16'h4321;
    localparam logic [15:0] H2_INIT = 16'h1234;
    localparam logic [15:0] H3_INIT = 16'h5678;

    localparam logic [15:0] MIX_CONST [128] = '{
        16'hd76a, 16'ha478, 16'he8c7, 16'hb756, 16'h2420, 16'h70db, 16'hc1bd, 16'hceee,
        16'hf57c, 16'h0faf, 16'h4787, 16'hc62a, 16'ha830, 16'h4613, 16'hfd46, 16'h9501,
        16'h6980, 16'h98d8, 16'h8b44, 16'hf7af, 16'hffff, 16'h5bb1, 16'h895c, 16'hd7be,
        16'h6b90, 16'h1122, 16'hfd98, 16'h7193, 16'ha679, 16'h438e, 16'h49b4, 16'h0821,
        16'hf61e, 16'h2562, 16'hc040, 16'hb340, 16'h265e, 16'h5a51, 16'he9b6, 16'hc7aa,
        16'hd62f, 16'h105d, 16'h0244, 16'h1453, 16'hd8a1, 16'he681, 16'he7d3, 16'hfbc8,
        16'h21e1, 16'hcde6, 16'hc337, 16'h07d6, 16'hf4d5, 16'h0d87, 16'h455a, 16'h14ed,
        16'ha9e3, 16'he905, 16'hfcef, 16'ha3f8, 16'h676f, 16'h02d9, 16'h8d2a, 16'h4c8a,
        16'hfffa, 16'h3942, 16'h8771, 16'hf681, 16'h6d9d, 16'h6122, 16'hfde5, 16'h380c,
        16'ha4be, 16'hea44, 16'h4bde, 16'hcfa9, 16'hf6bb, 16'h4b60, 16'hbebf, 16'hbc70,
        16'h289b, 16'h7ec6, 16'heaa1, 16'h27fa, 16'hd4ef, 16'h3085, 16'h0488, 16'h1d05,
        16'hd9d4, 16'hd039, 16'he6db, 16'h99e5, 16'h1fa2, 16'h7cf8, 16'hc4ac, 16'h5665,
        16'hf429, 16'h2244, 16'h432a, 16'hff97, 16'hab94, 16'h23a7, 16'hfc93, 16'ha039,
        16'h655b, 16'h59c3, 16'h8f0c, 16'hcc92, 16'hffef, 16'hf47d, 16'h8584, 16'h5dd1,
        16'h6fa8, 16'h7e4f, 16'hfe2c, 16'he6e0, 16'ha301, 16'h4314, 16'h4e08, 16'h11a1,
        16'hf753, 16'h7e82, 16'hbd3a, 16'hf235, 16'h2ad7, 16'hd2bb, 16'heb86, 16'hd391
    };

    function automatic logic [15:0] rotl4(input logic [15:0] v);
        return {v[11:0], v[15:12]};
    endfunction

endpackage
`default_nettype wire

@@ sv/insertion_ordered_hash_map.sv @@
`default_nettype none
// Insertion-ordered hash map, keys streamed one character per word.
// Input channel: opcode, key_char, key_end, put_value (valid/ready).
// Output channel: status, result_value; one word per key_end input.
// A non-final character is hashed in the cycle it is accepted.
// On the final character the entry memory (tag, value, links) is scanned
// one entry per cycle through its single read port; Put also finds the
// lowest free slot during the same scan. Delete adds a link read-modify-write
// on the same memory; neighbor reads add a link read and a neighbor read.
// Valid bits live in flip-flops, cleared at reset; tail resets to null.
// No clearing pass. The result holds in the output register until taken;
// a stalled receiver blocks the next input word only after a key end.
module insertion_ordered_hash_map #(
    parameter int ENTRIES = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [7:0]  i_key_char,
    input  wire logic        i_key_end,
    input  wire logic [63:0] i_put_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [1:0]  o_status,
    output logic      [63:0] o_result_value
);
    localparam int AW = $clog2(ENTRIES);
    localparam int LW = AW + 1;
    localparam logic [LW-1:0] NULL_L = LW'(ENTRIES);
    localparam int MW = 128 + 2 * LW;

    // memory word: {tag, value, prev, next}
    logic [MW-1:0] mem [ENTRIES];
    logic [MW-1:0] r_rd;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    logic [MW-1:0] wr_data;

    logic [ENTRIES-1:0] r_vld, n_vld;
    ihm_pkg::t_state r_st, n_st;
    logic [LW-1:0] r_idx, n_idx, r_hit, n_hit, r_free, n_free, r_tail, n_tail;
    logic [LW-1:0] r_p, n_p, r_n, n_n;
    logic [63:0]   r_tag, n_tag, r_val, n_val, r_res, n_res;
    logic [2:0]    r_op, n_op;
    logic [1:0]    r_sts, n_sts;
    logic [1:0]    r_o_sts, n_o_sts;
    logic [63:0]   r_o_res, n_o_res;
    logic          r_ov, n_ov, r_rdv, n_rdv;
    logic [63:0]   tag;
    logic          acc, hstep;

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        r_rd <= mem[rd_addr];
    end

    assign acc   = i_valid && o_ready;
    assign hstep = acc;
    assign o_ready = (r_st == ihm_pkg::S_IDLE);

    ihm_hash u_hash (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_step(hstep && !i_key_end), .i_restart(hstep && i_key_end),
        .i_char(i_key_char), .o_tag(tag)
    );

    always_comb begin
        n_st = r_st;
        case (r_st)
            ihm_pkg::S_IDLE:      if (acc && i_key_end) n_st = ihm_pkg::S_SCAN;
            ihm_pkg::S_SCAN:      if (r_idx == LW'(ENTRIES - 1)) n_st = ihm_pkg::S_SCAN_WAIT;
            ihm_pkg::S_SCAN_WAIT: n_st = ihm_pkg::S_DECIDE;
            ihm_pkg::S_DECIDE: begin
                n_st = ihm_pkg::S_OUT;
                case (r_op)
                    ihm_pkg::OP_PUT:
                        if (r_hit != NULL_L) n_st = ihm_pkg::S_WRITE_A;
                        else if (r_free != NULL_L) n_st = (r_tail != NULL_L) ?
                            ihm_pkg::S_LINK_RD : ihm_pkg::S_WRITE_A;
                    ihm_pkg::OP_DEL, ihm_pkg::OP_GET,
                    ihm_pkg::OP_PREV, ihm_pkg::OP_NEXT:
                        if (r_hit != NULL_L) n_st = ihm_pkg::S_LINK_RD;
                    default: n_st = ihm_pkg::S_OUT;
                endcase
            end
            ihm_pkg::S_LINK_RD:   n_st = ihm_pkg::S_LINK_WAIT;
            ihm_pkg::S_LINK_WAIT: begin
                case (r_op)
                    ihm_pkg::OP_PUT, ihm_pkg::OP_DEL: n_st = ihm_pkg::S_WRITE_A;
                    ihm_pkg::OP_PREV, ihm_pkg::OP_NEXT: n_st = ihm_pkg::S_NBR_RD;
                    default: n_st = ihm_pkg::S_OUT;
                endcase
            end
            ihm_pkg::S_WRITE_A:   n_st = ihm_pkg::S_WRITE_B;
            ihm_pkg::S_WRITE_B:   n_st = (r_op == ihm_pkg::OP_DEL) ?
                                         ihm_pkg::S_DEL_FIX : ihm_pkg::S_OUT;
            ihm_pkg::S_DEL_FIX:   n_st = ihm_pkg::S_OUT;
            ihm_pkg::S_NBR_RD:    n_st = ihm_pkg::S_NBR_WAIT;
            ihm_pkg::S_NBR_WAIT:  n_st = ihm_pkg::S_OUT;
            ihm_pkg::S_OUT:       if (!r_ov || i_ready) n_st = ihm_pkg::S_IDLE;
            default:              n_st = ihm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_idx = r_idx; n_hit = r_hit; n_free = r_free; n_tail = r_tail;
        n_p = r_p; n_n = r_n; n_tag = r_tag; n_val = r_val; n_res = r_res;
        n_op = r_op; n_sts = r_sts; n_ov = r_ov; n_rdv = 1'b0; n_vld = r_vld;
        n_o_sts = r_o_sts; n_o_res = r_o_res;
        rd_addr = r_idx[AW-1:0];
        wr_en = 1'b0; wr_addr = '0; wr_data = r_rd;
        if (r_ov && i_ready) n_ov = 1'b0;
        case (r_st)
            ihm_pkg::S_IDLE: if (acc && i_key_end) begin
                n_tag = tag; n_val = i_put_value; n_op = i_opcode;
                n_idx = '0; n_hit = NULL_L; n_free = NULL_L;
                n_sts = ihm_pkg::ST_NONE; n_res = '0;
            end
            ihm_pkg::S_SCAN, ihm_pkg::S_SCAN_WAIT: begin
                if (r_st == ihm_pkg::S_SCAN) begin
                    n_idx = r_idx + 1'b1;
                    n_rdv = 1'b1;
                    if (!r_vld[r_idx[AW-1:0]] && r_free == NULL_L) n_free = r_idx;
                end
                // r_rd holds entry r_idx - 1
                if (r_rdv && r_vld[AW'(r_idx - 1'b1)] && r_rd[MW-1 -: 64] == r_tag
                    && r_hit == NULL_L)
                    n_hit = r_idx - 1'b1;
            end
            ihm_pkg::S_DECIDE: begin
                if (r_op == ihm_pkg::OP_PUT && r_hit == NULL_L && r_free == NULL_L)
                    n_sts = ihm_pkg::ST_FULL;
                if (r_op == ihm_pkg::OP_PUT && r_hit == NULL_L) n_p = r_tail;
            end
            ihm_pkg::S_LINK_RD: begin
                rd_addr = (r_op == ihm_pkg::OP_PUT) ? r_tail[AW-1:0] : r_hit[AW-1:0];
            end
            ihm_pkg::S_LINK_WAIT: begin
                if (r_op == ihm_pkg::OP_GET) begin
                    n_sts = ihm_pkg::ST_DONE; n_res = r_rd[MW-65 -: 64];
                end else if (r_op == ihm_pkg::OP_PUT) begin
                    // tail.next := new slot
                    wr_en = 1'b1; wr_addr = r_tail[AW-1:0];
                    wr_data = {r_rd[MW-1:LW], r_free};
                end else begin
                    n_p = r_rd[2*LW-1:LW]; n_n = r_rd[LW-1:0];
                end
            end
            ihm_pkg::S_WRITE_A: begin
                n_sts = ihm_pkg::ST_DONE;
                if (r_op == ihm_pkg::OP_PUT) begin
                    wr_en = 1'b1;
                    if (r_hit != NULL_L) begin
                        // rewrite value, keep links: re-read first
                        rd_addr = r_hit[AW-1:0];
                    end else begin
                        wr_addr = r_free[AW-1:0];
                        wr_data = {r_tag, r_val, r_p, NULL_L};
                        n_vld[r_free[AW-1:0]] = 1'b1;
                        n_tail = r_free;
                    end
                    if (r_hit != NULL_L) wr_en = 1'b0;
                end else begin
                    n_vld[r_hit[AW-1:0]] = 1'b0;
                    if (r_tail == r_hit) n_tail = r_p;
                    if (r_p != NULL_L) rd_addr = r_p[AW-1:0];
                end
            end
            ihm_pkg::S_WRITE_B: begin
                if (r_op == ihm_pkg::OP_PUT) begin
                    if (r_hit != NULL_L) begin
                        wr_en = 1'b1; wr_addr = r_hit[AW-1:0];
                        wr_data = {r_rd[MW-1 -: 64], r_val, r_rd[2*LW-1:0]};
                    end
                end else begin
                    if (r_p != NULL_L) begin
                        wr_en = 1'b1; wr_addr = r_p[AW-1:0];
                        wr_data = {r_rd[MW-1:LW], r_n};
                    end
                    rd_addr = r_n[AW-1:0];
                end
            end
            ihm_pkg::S_DEL_FIX: begin
                // successor's prev := predecessor
                if (r_n != NULL_L) begin
                    wr_en = 1'b1; wr_addr = r_n[AW-1:0];
                    wr_data = {r_rd[MW-1:2*LW], r_p, r_rd[LW-1:0]};
                end
            end
            ihm_pkg::S_NBR_RD: begin
                if (r_op == ihm_pkg::OP_PREV) rd_addr = r_p[AW-1:0];
                else rd_addr = r_n[AW-1:0];
            end
            ihm_pkg::S_NBR_WAIT: begin
                if ((r_op == ihm_pkg::OP_PREV && r_p != NULL_L) ||
                    (r_op == ihm_pkg::OP_NEXT && r_n != NULL_L)) begin
                    n_sts = ihm_pkg::ST_DONE; n_res = r_rd[MW-65 -: 64];
                end
            end
            ihm_pkg::S_OUT: if (!r_ov || i_ready) begin
                n_ov = 1'b1; n_o_sts = r_sts; n_o_res = r_res;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ihm_pkg::S_IDLE; r_vld <= '0; r_tail <= NULL_L;
            r_ov <= 1'b0; r_rdv <= 1'b0;
            r_o_sts <= ihm_pkg::ST_DONE; r_o_res <= '0;
        end else begin
            r_st <= n_st; r_vld <= n_vld; r_tail <= n_tail;
            r_ov <= n_ov; r_rdv <= n_rdv;
            r_o_sts <= n_o_sts; r_o_res <= n_o_res;
        end
        r_idx <= n_idx; r_hit <= n_hit; r_free <= n_free; r_p <= n_p; r_n <= n_n;
        r_tag <= n_tag; r_val <= n_val; r_res <= n_res; r_op <= n_op; r_sts <= n_sts;
    end

    assign o_valid = r_ov;
    assign o_status = r_o_sts;
    assign o_result_value = r_o_res;
endmodule
`default_nettype wire

@@ sv/ihm_hash.sv @@
`default_nettype none
// Two-round per-character mixer over four 16-bit words.
module ihm_hash (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire logic        i_restart,
    input  wire logic [7:0]  i_char,
    output logic      [63:0] o_tag
);
    logic [15:0] r_h [4];
    logic [15:0] m, f1, a1, b1, c1, d1, f2, a2, b2, c2, d2;

    always_comb begin
        m  = ihm_pkg::MIX_CONST[i_char[6:0]];
        f1 = ((r_h[1] & r_h[2]) | (~r_h[1] & r_h[3])) + r_h[0] + m;
        a1 = r_h[3];
        d1 = r_h[2];
        c1 = r_h[1];
        b1 = r_h[1] + ihm_pkg::rotl4(f1);
        f2 = (b1 ^ c1 ^ d1) + a1 + m;
        a2 = d1;
        d2 = c1;
        c2 = b1;
        b2 = b1 + ihm_pkg::rotl4(f2);
        o_tag = {r_h[0] + a2, r_h[1] + b2, r_h[2] + c2, r_h[3] + d2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_h[0] <= ihm_pkg::H0_INIT;
            r_h[1] <= ihm_pkg::H1_INIT;
            r_h[2] <= ihm_pkg::H2_INIT;
            r_h[3] <= ihm_pkg::H3_INIT;
        end else if (i_step) begin
            r_h[0] <= o_tag[63:48];
            r_h[1] <= o_tag[47:32];
            r_h[2] <= o_tag[31:16];
            r_h[3] <= o_tag[15:0];
        end
    end
endmodule
`default_nettype wire

@@ sv/ihm_checker.sv @@
`default_nettype none
module ihm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [1:0]  o_status,
    input wire logic [63:0] o_result_value
);
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3) else $error("bad status");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ihm_pkg::ST_DONE) |-> o_result_value == 64'd0)
        else $error("nonzero value on miss");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_result_value) && $stable(o_status))
        else $error("output dropped");
    // a result only appears while the input side is busy
    a_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(o_ready))
        else $error("result while idle");
endmodule

bind insertion_ordered_hash_map ihm_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
    .o_result_value(o_result_value)
);
`default_nettype wire
